@@ design/imm_pkg.sv @@
// ============================================================================
// imm_pkg - integer matrix multiply shared definitions
// Item types, opcodes and control bundles used by the core and its units.
// ============================================================================
package imm_pkg;

    localparam int ELEM_W  = 32;
    localparam int INDEX_W = 4;
    localparam int LEN_W   = 5;

    localparam logic [1:0] OP_WRITE_A = 2'd0;
    localparam logic [1:0] OP_WRITE_B = 2'd1;
    localparam logic [1:0] OP_COMPUTE = 2'd2;

    typedef struct packed {
        logic [1:0]         opcode;
        logic [INDEX_W-1:0] row_index;
        logic [INDEX_W-1:0] col_index;
        logic [ELEM_W-1:0]  element_value;
    } in_item_t;

    typedef struct packed {
        logic [ELEM_W-1:0]  product_value;
        logic [INDEX_W-1:0] out_row;
        logic [INDEX_W-1:0] out_col;
    } out_item_t;

    // sequencer to multiply-accumulate unit
    typedef struct packed {
        logic clear;  // zero the accumulator
        logic issue;  // operand read issued this cycle
    } mac_ctrl_t;

endpackage

@@ design/imm_ram.sv @@
// ============================================================================
// imm_ram - element store
// Single write port, single read port, registered read data.
// ============================================================================
module imm_ram #(
    parameter int DEPTH = 256,
    parameter int AW    = 8
) (
    input  logic                      clk,
    input  logic                      wr_en,
    input  logic [AW-1:0]             wr_addr,
    input  logic [imm_pkg::ELEM_W-1:0] wr_data,
    input  logic                      rd_en,
    input  logic [AW-1:0]             rd_addr,
    output logic [imm_pkg::ELEM_W-1:0] rd_data
);

    logic [imm_pkg::ELEM_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

@@ design/imm_mac.sv @@
// ============================================================================
// imm_mac - shared multiply-accumulate unit
// Two stages behind the store read: registered 32x32 product (low word),
// then a wrapping 32-bit accumulate.
// ============================================================================
module imm_mac (
    input  logic                       clk,
    input  logic                       rst_n,
    input  imm_pkg::mac_ctrl_t         ctrl,
    input  logic [imm_pkg::ELEM_W-1:0] a_data,
    input  logic [imm_pkg::ELEM_W-1:0] b_data,
    output logic [imm_pkg::ELEM_W-1:0] acc,
    output logic                       busy
);

    logic                       rd_valid_reg;
    logic                       mul_valid_reg;
    logic [imm_pkg::ELEM_W-1:0] mul_reg;
    logic [imm_pkg::ELEM_W-1:0] acc_reg;
    logic [imm_pkg::ELEM_W-1:0] prod_lo;

    // only the low word survives the wrap
    assign prod_lo = a_data * b_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_valid_reg  <= 1'b0;
            mul_valid_reg <= 1'b0;
        end
        else
        begin
            rd_valid_reg  <= ctrl.issue;
            mul_valid_reg <= rd_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_valid_reg)
        begin
            mul_reg <= prod_lo;
        end
        if (ctrl.clear)
        begin
            acc_reg <= '0;
        end
        else if (mul_valid_reg)
        begin
            acc_reg <= acc_reg + mul_reg;
        end
    end

    assign acc  = acc_reg;
    assign busy = rd_valid_reg | mul_valid_reg;

endmodule

@@ design/integer_matrix_multiply_core.sv @@
// ============================================================================
// integer_matrix_multiply_core - 32-bit integer matrix multiply engine
// Loads A and B one element per item and returns one element of A*B per
// compute item.
// ============================================================================
// A write item (opcode 0 for A, 1 for B) is taken while idle and gives no
// result; writes outside the MAX_DIM x MAX_DIM store are dropped. A compute
// item (opcode 2) walks the inner dimension through one shared multiplier,
// one term per cycle, with inner_length reads on the two element stores,
// then a drain of the read/multiply/accumulate pipe, then a load of the
// result register. The input is stalled while a compute is in flight;
// writes may follow each other every cycle, and a new item is taken while a
// finished result still waits on out_stall. inner_length above MAX_DIM is
// treated as MAX_DIM, zero gives a result of 0, and a row or column outside
// the store gives 0. Store contents are undefined until written.
module integer_matrix_multiply_core #(
    parameter int MAX_DIM = 16
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  imm_pkg::in_item_t         in_item,
    output logic                      out_valid,
    input  logic                      out_stall,
    output imm_pkg::out_item_t        out_item,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [imm_pkg::LEN_W-1:0] cfg_data
);

    localparam int DEPTH = MAX_DIM * MAX_DIM;
    localparam int AW    = $clog2(DEPTH);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_RUN   = 4'b0010,
        ST_DRAIN = 4'b0100,
        ST_PUSH  = 4'b1000
    } state_t;

    state_t                         state_reg, state_next;
    logic [imm_pkg::LEN_W-1:0]      len_reg;
    logic [imm_pkg::LEN_W-1:0]      n_reg, n_next;
    logic [imm_pkg::LEN_W-1:0]      k_reg, k_next;
    logic [imm_pkg::LEN_W-1:0]      n_sat;
    logic [imm_pkg::INDEX_W-1:0]    row_reg, col_reg;
    logic                           zero_reg;
    logic                           out_valid_reg;
    imm_pkg::out_item_t             out_item_reg;

    logic                           in_accept;
    logic                           wr_in_range;
    logic [AW-1:0]                  wr_addr;
    logic                           wr_a_en, wr_b_en;
    logic [AW-1:0]                  rd_a_addr, rd_b_addr;
    logic [imm_pkg::ELEM_W-1:0]     a_data, b_data;
    logic [imm_pkg::ELEM_W-1:0]     acc;
    logic                           mac_busy;
    imm_pkg::mac_ctrl_t             mac_ctrl;
    logic                           out_free;
    logic                           start;

    assign cfg_ready = 1'b1;
    assign in_stall  = (state_reg != ST_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign start     = in_accept && (in_item.opcode == imm_pkg::OP_COMPUTE);
    assign out_free  = !out_valid_reg || !out_stall;

    always_comb
    begin
        if (int'(len_reg) > MAX_DIM)
        begin
            n_sat = imm_pkg::LEN_W'(MAX_DIM);
        end
        else
        begin
            n_sat = len_reg;
        end
    end

    // store addressing
    assign wr_in_range = (int'(in_item.row_index) < MAX_DIM) &&
                         (int'(in_item.col_index) < MAX_DIM);
    assign wr_addr   = AW'(int'(in_item.row_index) * MAX_DIM + int'(in_item.col_index));
    assign wr_a_en   = in_accept && wr_in_range && (in_item.opcode == imm_pkg::OP_WRITE_A);
    assign wr_b_en   = in_accept && wr_in_range && (in_item.opcode == imm_pkg::OP_WRITE_B);
    assign rd_a_addr = AW'(int'(row_reg) * MAX_DIM + int'(k_reg));
    assign rd_b_addr = AW'(int'(k_reg) * MAX_DIM + int'(col_reg));

    assign mac_ctrl.clear = start;
    assign mac_ctrl.issue = (state_reg == ST_RUN);

    always_comb
    begin
        state_next = state_reg;
        n_next     = n_reg;
        k_next     = k_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    n_next = n_sat;
                    k_next = '0;
                    state_next = (n_sat == '0) ? ST_DRAIN : ST_RUN;
                end
            end
            ST_RUN:
            begin
                k_next = k_reg + 1'b1;
                if (k_next == n_reg)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (!mac_busy)
                begin
                    state_next = ST_PUSH;
                end
            end
            ST_PUSH:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            len_reg       <= imm_pkg::LEN_W'(1);
            n_reg         <= '0;
            k_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            n_reg     <= n_next;
            k_reg     <= k_next;
            if (cfg_valid && cfg_ready)
            begin
                len_reg <= cfg_data;
            end
            if (state_reg == ST_PUSH && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            row_reg  <= in_item.row_index;
            col_reg  <= in_item.col_index;
            zero_reg <= (int'(in_item.row_index) >= MAX_DIM) ||
                        (int'(in_item.col_index) >= MAX_DIM);
        end
        if (state_reg == ST_PUSH && out_free)
        begin
            out_item_reg.product_value <= zero_reg ? '0 : acc;
            out_item_reg.out_row       <= row_reg;
            out_item_reg.out_col       <= col_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    imm_ram #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_ram_a (
        .clk     (clk),
        .wr_en   (wr_a_en),
        .wr_addr (wr_addr),
        .wr_data (in_item.element_value),
        .rd_en   (mac_ctrl.issue),
        .rd_addr (rd_a_addr),
        .rd_data (a_data)
    );

    imm_ram #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_ram_b (
        .clk     (clk),
        .wr_en   (wr_b_en),
        .wr_addr (wr_addr),
        .wr_data (in_item.element_value),
        .rd_en   (mac_ctrl.issue),
        .rd_addr (rd_b_addr),
        .rd_data (b_data)
    );

    imm_mac u_mac (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (mac_ctrl),
        .a_data (a_data),
        .b_data (b_data),
        .acc    (acc),
        .busy   (mac_busy)
    );

`ifndef SYNTHESIS
    a_run_in_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_RUN |-> k_reg < n_reg)
        else $error("term counter ran past inner length");

    a_compute_starts: assert property (@(posedge clk) disable iff (!rst_n)
        start |=> (state_reg == ST_RUN || state_reg == ST_DRAIN))
        else $error("compute item did not start the sequencer");

    a_push_pipe_empty: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_PUSH |-> !mac_busy)
        else $error("result loaded with terms still in the pipe");

    a_accept_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !in_stall |-> state_reg == ST_IDLE)
        else $error("input open while busy");

    a_result_from_push: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(state_reg == ST_PUSH))
        else $error("result appeared without a finished compute");
`endif

endmodule
